// ===== hdl/pfr_pkg.sv =====
// Shared types and constants for the additive-checksum packet framer.
package pfr_pkg;

    localparam int DATA_W = 8;
    localparam int LEN_W  = 16;
    localparam int NUM_SLOTS = 6;

    localparam logic [LEN_W-1:0] MARKER_RESET = 16'hBEEF;

    typedef logic [NUM_SLOTS-1:0] slot_mask_t;

    // One bit per frame byte an item can produce, in emission order.
    localparam slot_mask_t SLOT_MARK_HI = 6'b000001;
    localparam slot_mask_t SLOT_MARK_LO = 6'b000010;
    localparam slot_mask_t SLOT_LEN_HI  = 6'b000100;
    localparam slot_mask_t SLOT_LEN_LO  = 6'b001000;
    localparam slot_mask_t SLOT_PAYLOAD = 6'b010000;
    localparam slot_mask_t SLOT_CSUM    = 6'b100000;

    typedef struct packed {
        logic [DATA_W-1:0] payload_byte;
        logic [LEN_W-1:0]  packet_length;
    } item_t;

    typedef struct packed {
        logic       fire;
        slot_mask_t grant;
    } emit_t;

endpackage

// ===== hdl/pfr_item_reg.sv =====
// Input register: holds one item and the mask of frame bytes it still owes.
module pfr_item_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // payload_byte[7:0], packet_length[23:8]
    input  logic              s_tlast,
    input  logic [1:0]        s_tuser,   // starts_packet[0], carries_byte[1]
    input  pfr_pkg::emit_t    emit,
    output pfr_pkg::item_t    item,
    output pfr_pkg::slot_mask_t pend
);
    import pfr_pkg::*;

    slot_mask_t pend_reg, pend_next, pend_left, new_mask;
    logic       inside_reg, inside_next;
    item_t      item_reg;
    logic       accept, start, live;

    assign start = s_tuser[0];
    assign live  = start | inside_reg;

    assign pend_left = pend_reg & ~(emit.fire ? emit.grant : '0);
    assign s_tready  = (pend_left == '0);
    assign accept    = s_tvalid && s_tready;

    // An item outside a frame that does not open one produces nothing.
    assign new_mask = {s_tlast & live, s_tuser[1] & live, {4{start}}};

    always_comb begin
        pend_next   = pend_left;
        inside_next = inside_reg;
        if (accept) begin
            pend_next   = new_mask;
            inside_next = live & ~s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg   <= '0;
            inside_reg <= 1'b0;
        end else begin
            pend_reg   <= pend_next;
            inside_reg <= inside_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.payload_byte  <= s_tdata[DATA_W-1:0];
            item_reg.packet_length <= s_tdata[DATA_W+LEN_W-1:DATA_W];
        end
    end

    assign item = item_reg;
    assign pend = pend_reg;

    // A new transaction never lands on bytes that are still owed.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> (pend_reg == '0) || (emit.fire && pend_reg == emit.grant))
        else $error("item accepted over pending bytes");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> (pend_reg == '0 && !inside_reg))
        else $error("state not cleared by reset");

endmodule

// ===== hdl/pfr_byte_gen.sv =====
// Byte generator: picks the next owed frame byte, keeps the sum, drives the output register.
module pfr_byte_gen (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  pfr_pkg::item_t      item,
    input  pfr_pkg::slot_mask_t pend,
    output pfr_pkg::emit_t      emit,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // out_byte[7:0]
    output logic                m_tlast    // frame_end
);
    import pfr_pkg::*;

    logic [LEN_W-1:0]  marker_reg;
    logic [DATA_W-1:0] sum_reg, sum_next;
    logic [DATA_W-1:0] byte_sel;
    logic [DATA_W-1:0] data_reg;
    logic              last_reg, valid_reg, valid_next;
    logic              out_free;
    slot_mask_t        grant;

    assign out_free = !valid_reg || m_tready;
    assign grant    = pend & (~pend + 1'b1);
    assign emit.fire  = (pend != '0) && out_free;
    assign emit.grant = grant;

    always_comb begin
        case (grant)
            SLOT_MARK_HI: byte_sel = marker_reg[LEN_W-1:DATA_W];
            SLOT_MARK_LO: byte_sel = marker_reg[DATA_W-1:0];
            SLOT_LEN_HI:  byte_sel = item.packet_length[LEN_W-1:DATA_W];
            SLOT_LEN_LO:  byte_sel = item.packet_length[DATA_W-1:0];
            SLOT_PAYLOAD: byte_sel = item.payload_byte;
            SLOT_CSUM:    byte_sel = sum_reg;
            default:      byte_sel = '0;
        endcase
    end

    // Restart on the first marker byte, clear after the checksum.
    always_comb begin
        sum_next = sum_reg;
        if (emit.fire) begin
            if (grant == SLOT_MARK_HI) begin
                sum_next = byte_sel;
            end else if (grant == SLOT_CSUM) begin
                sum_next = '0;
            end else begin
                sum_next = sum_reg + byte_sel;
            end
        end
    end

    assign valid_next = emit.fire || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marker_reg <= MARKER_RESET;
            sum_reg    <= '0;
            valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                marker_reg <= cfg_wdata;
            end
            sum_reg   <= sum_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit.fire) begin
            data_reg <= byte_sel;
            last_reg <= (grant == SLOT_CSUM);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

    a_grant_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        emit.fire |-> ($onehot(grant) && ((grant & pend) == grant)))
        else $error("grant is not a single owed byte");

    a_sum_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit.fire && grant == SLOT_CSUM) |=> (sum_reg == '0 && m_tlast))
        else $error("sum not cleared after checksum");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend != '0 && valid_reg && !m_tready) |-> !emit.fire)
        else $error("byte issued into a stalled output");

endmodule

// ===== hdl/packet_framer_with_sum_checksum.sv =====
// Top level of the additive-checksum packet framer.
//
// Input stream (s_*): one transaction per item. tdata carries the payload
// byte and the declared length (read only on the first item), tlast marks
// the last item of a packet, tuser flags the first item and whether the
// item carries a byte. Output stream (m_*): one frame byte per transaction,
// tlast high on the checksum byte. A frame is marker (high byte first),
// length (high byte first), payload, then the modulo-256 sum of all bytes
// before it. cfg_we/cfg_wdata write the marker; write it only while idle.
// The item register holds the mask of frame bytes an item owes (1 to 6, or
// none), issued into the output register; the next item is taken in the
// cycle its last owed byte is issued. While m_tready does not stall, a plain
// payload item sustains one item per cycle. The output register is the limit:
// while m_tready is high, one byte per cycle leaves it.
// Reset clears the open-frame flag, the sum and all valid flags, and sets
// the marker to 0xBEEF. A stall on m_tready holds the output byte and drops
// s_tready once the held item has bytes left to send.
module packet_framer_with_sum_checksum (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // payload_byte[7:0], packet_length[23:8]
    input  logic        s_tlast,   // ends_packet
    input  logic [1:0]  s_tuser,   // starts_packet[0], carries_byte[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tlast    // frame_end
);
    import pfr_pkg::*;

    item_t      item;
    slot_mask_t pend;
    emit_t      emit;

    pfr_item_reg u_item_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .emit     (emit),
        .item     (item),
        .pend     (pend)
    );

    pfr_byte_gen u_byte_gen (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .pend      (pend),
        .emit      (emit),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== verif/tb_packet_framer_with_sum_checksum.sv =====
// Self-checking testbench for the packet framer: directed table, random packets, byte scoreboard.
module tb_packet_framer_with_sum_checksum;
    import pfr_pkg::*;

    localparam int CLK_HALF        = 2;
    localparam int RESET_CYCLES    = 11;
    localparam int DRAIN_CYCLES    = 8;
    localparam int STALL_CYCLES    = 160;
    localparam int STALL_AFTER     = 60;
    localparam int ITEMS_PER_PHASE = 65;
    localparam int IDLE_PCT        = 16;
    localparam int MAX_REPORTS     = 10;
    localparam int RUN_LIMIT       = 800000;

    typedef struct packed {
        logic [DATA_W-1:0] pbyte;
        logic [LEN_W-1:0]  plen;
        logic              sop;
        logic              eop;
        logic              has_byte;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              last;
    } frame_byte_t;

    // typed_bytes lists the expected frame bytes first to last from the top byte down
    typedef struct packed {
        in_item_t    it;
        logic        typed;
        logic [2:0]  n_typed;
        logic [47:0] typed_bytes;
    } stim_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    // framer state as the testbench sees it
    logic [LEN_W-1:0]  fr_marker;
    logic [DATA_W-1:0] fr_sum;
    logic              fr_open;

    frame_byte_t staged[$];
    frame_byte_t frame_bytes_due[$];
    stim_row_t   directed_rows[$];

    int n_mismatch    = 0;
    int n_bytes_seen  = 0;
    int phase_items   = 0;
    bit steady        = 1'b0;
    bit stall_pending = 1'b1;

    packet_framer_with_sum_checksum u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    function automatic in_item_t mk_item(logic [DATA_W-1:0] pbyte, logic [LEN_W-1:0] plen,
                                         logic sop, logic eop, logic has_byte);
        in_item_t it;
        it.pbyte    = pbyte;
        it.plen     = plen;
        it.sop      = sop;
        it.eop      = eop;
        it.has_byte = has_byte;
        return it;
    endfunction

    function automatic stim_row_t typed_row(in_item_t it, int n, logic [47:0] bytes);
        stim_row_t row;
        row.it          = it;
        row.typed       = 1'b1;
        row.n_typed     = 3'(n);
        row.typed_bytes = bytes;
        return row;
    endfunction

    function automatic stim_row_t plain_row(in_item_t it);
        stim_row_t row;
        row             = '0;
        row.it          = it;
        return row;
    endfunction

    function automatic void add_summed(logic [DATA_W-1:0] b);
        fr_sum = fr_sum + b;
        staged.push_back({b, 1'b0});
    endfunction

    // Compute the frame bytes one item causes into staged; return 0 if the item is dropped.
    function automatic bit advance_framer(in_item_t it);
        staged.delete();
        if (it.sop) begin
            fr_sum  = '0;
            fr_open = 1'b1;
            add_summed(fr_marker[15:8]);
            add_summed(fr_marker[7:0]);
            add_summed(it.plen[15:8]);
            add_summed(it.plen[7:0]);
        end else if (!fr_open) begin
            return 1'b0;
        end
        if (it.has_byte) begin
            add_summed(it.pbyte);
        end
        if (it.eop) begin
            staged.push_back({fr_sum, 1'b1});
            fr_sum  = '0;
            fr_open = 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic send_item(stim_row_t row);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {row.it.plen, row.it.pbyte};
        s_tlast  <= row.it.eop;
        s_tuser  <= {row.it.has_byte, row.it.sop};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (advance_framer(row.it)) begin
            phase_items++;
        end
        if (row.typed) begin
            for (int k = 0; k < row.n_typed; k++) begin
                frame_bytes_due.push_back({row.typed_bytes[47 - 8*k -: 8],
                                           row.it.eop && (k == row.n_typed - 1)});
            end
        end else begin
            foreach (staged[k]) frame_bytes_due.push_back(staged[k]);
        end
    endtask

    task automatic wait_frames_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (frame_bytes_due.size() != 0) @(posedge aclk);
        // dropped items may still be in flight with nothing to show for it
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic update_marker(logic [LEN_W-1:0] value);
        wait_frames_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        fr_marker = value;
    endtask

    // Mostly well-formed packets; some noise, cut-off frames and mismatched lengths.
    task automatic send_packet();
        int unsigned      r;
        int unsigned      len;
        bit               cut;
        bit               split_end;
        logic [LEN_W-1:0] declared;
        r = $urandom_range(99);
        if (r < 10) begin
            send_item(plain_row(mk_item(DATA_W'($urandom), LEN_W'($urandom),
                                        1'($urandom), 1'($urandom), 1'($urandom))));
            return;
        end
        len       = (r < 15) ? $urandom_range(64, 20) : $urandom_range(6);
        declared  = ($urandom_range(9) == 0) ? LEN_W'($urandom) : LEN_W'(len);
        cut       = ($urandom_range(19) == 0);
        split_end = ($urandom_range(7) == 0);
        if (len == 0) begin
            send_item(plain_row(mk_item(DATA_W'($urandom), declared, 1'b1, !cut, 1'b0)));
            return;
        end
        for (int i = 0; i < len; i++) begin
            if (i != 0 && $urandom_range(15) == 0) begin
                send_item(plain_row(mk_item(DATA_W'($urandom), LEN_W'($urandom),
                                            1'b0, 1'b0, 1'b0)));
            end
            send_item(plain_row(mk_item(DATA_W'($urandom),
                                        (i == 0) ? declared : LEN_W'($urandom),
                                        i == 0, (i == len - 1) && !cut && !split_end, 1'b1)));
        end
        if (split_end && !cut) begin
            send_item(plain_row(mk_item(DATA_W'($urandom), LEN_W'($urandom),
                                        1'b0, 1'b1, 1'b0)));
        end
    endtask

    function automatic void report(string field, logic [7:0] want, logic [7:0] got);
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS) begin
            $display("mismatch on frame byte %0d, %s: expected %h, got %h",
                     n_bytes_seen, field, want, got);
        end
    endfunction

    task automatic take_frame_byte();
        frame_byte_t want;
        n_bytes_seen++;
        if (frame_bytes_due.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS) begin
                $display("unexpected frame byte %0d: %h, tlast %b",
                         n_bytes_seen, m_tdata, m_tlast);
            end
            return;
        end
        want = frame_bytes_due.pop_front();
        if (m_tdata !== want.data) report("out_byte", want.data, m_tdata);
        if (m_tlast !== want.last) report("frame_end", 8'(want.last), 8'(m_tlast));
    endtask

    // Receiver: random backpressure plus one long hold-off to fill the block.
    initial begin
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                take_frame_byte();
            end
            if (stall_pending && n_bytes_seen >= STALL_AFTER) begin
                stall_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge aclk);
            end
            m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin
        logic [LEN_W-1:0] markers [4];
        fr_marker = MARKER_RESET;
        fr_sum    = '0;
        fr_open   = 1'b0;

        // empty packet, then items on a closed and an open frame
        directed_rows.push_back(typed_row(mk_item(8'h00, 16'h0000, 1, 1, 0), 5,
                                          48'hBEEF_0000_AD00));
        directed_rows.push_back(typed_row(mk_item(8'h55, 16'h1234, 0, 1, 1), 0, '0));
        directed_rows.push_back(typed_row(mk_item(8'hFF, 16'hFFFF, 1, 0, 1), 5,
                                          48'hBEEF_FFFF_FF00));
        directed_rows.push_back(typed_row(mk_item(8'h00, 16'h0000, 0, 0, 1), 1, '0));
        directed_rows.push_back(typed_row(mk_item(8'hFF, 16'hFFFF, 0, 0, 0), 0, '0));
        directed_rows.push_back(typed_row(mk_item(8'h80, 16'h8000, 0, 1, 1), 2,
                                          48'h802A_0000_0000));
        directed_rows.push_back(typed_row(mk_item(8'hA5, 16'h00FF, 0, 0, 1), 0, '0));
        directed_rows.push_back(plain_row(mk_item(8'h01, 16'h0001, 1, 1, 1)));
        directed_rows.push_back(plain_row(mk_item(8'hA5, 16'h0003, 1, 0, 1)));
        // restart abandons the open frame
        directed_rows.push_back(plain_row(mk_item(8'h5A, 16'h0002, 1, 0, 1)));
        directed_rows.push_back(plain_row(mk_item(8'hC3, 16'h5A5A, 0, 1, 1)));
        directed_rows.push_back(plain_row(mk_item(8'h3C, 16'h0000, 1, 0, 0)));
        directed_rows.push_back(plain_row(mk_item(8'h96, 16'hFF00, 0, 1, 0)));
        directed_rows.push_back(plain_row(mk_item(8'h7F, 16'h7FFF, 1, 1, 1)));
        directed_rows.push_back(plain_row(mk_item(8'h0F, 16'hF0F0, 0, 0, 0)));

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) send_item(directed_rows[i]);

        markers = '{16'h0000, 16'hFFFF, LEN_W'($urandom), MARKER_RESET};
        foreach (markers[p]) begin
            update_marker(markers[p]);
            steady      = (p == 1);
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) send_packet();
        end
        steady = 1'b0;

        wait_frames_drained();
        if (n_mismatch == 0 && frame_bytes_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #RUN_LIMIT;
        $display("FAILURE");
        $finish;
    end

endmodule
